[rtl/qea_pkg.sv]
// ----------------------------------------------------------------------------
// qea_pkg: shared types and constants for the quadrature encoder accumulator
// Word formats, register indexes and the full-step decoder state table.
// ----------------------------------------------------------------------------
package qea_pkg;

    // accumulator width and the width of the sum before clamping
    localparam int VALUE_W = 32;
    localparam int SUM_W   = ((VALUE_W > 32) ? VALUE_W : 32) + 2;

    // APB address width: three registers at byte addresses 0, 4, 8
    localparam int ADDR_W = 4;

    // decoder table entry layout: state in low nibble, event in bits 5:4
    localparam logic [5:0] EV_CW   = 6'h10;
    localparam logic [5:0] EV_CCW  = 6'h20;
    localparam logic [5:0] EV_MASK = 6'h30;
    localparam logic [5:0] ST_MASK = 6'h0f;

    localparam logic [2:0] ST_START = 3'd0;

    // register indexes (paddr[3:2])
    typedef enum logic [1:0] {
        REG_STEP = 2'd0,
        REG_MIN  = 2'd1,
        REG_MAX  = 2'd2
    } t_reg_idx;

    // completed step reported on the output
    typedef enum logic [1:0] {
        DIR_IDLE = 2'd0,
        DIR_CW   = 2'd1,
        DIR_CCW  = 2'd2
    } t_dir;

    typedef struct packed {
        logic pin_b;
        logic pin_a;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         direction;
    } t_out_word;

    // configuration handed from the register file to the datapath
    typedef struct packed {
        logic [30:0]        step_size;
        logic signed [31:0] min_value;
        logic signed [31:0] max_value;
    } t_cfg;

    // next state and event, indexed by current state and {pin_b, pin_a}
    localparam logic [5:0] NEXT_TAB [0:7][0:3] = '{
        '{6'h00, 6'h02, 6'h04, 6'h00},
        '{6'h03, 6'h00, 6'h01, 6'h10},
        '{6'h03, 6'h02, 6'h00, 6'h00},
        '{6'h03, 6'h02, 6'h01, 6'h00},
        '{6'h06, 6'h00, 6'h04, 6'h00},
        '{6'h06, 6'h05, 6'h00, 6'h20},
        '{6'h06, 6'h05, 6'h04, 6'h00},
        '{6'h00, 6'h00, 6'h00, 6'h00}
    };

endpackage

[rtl/qea_regs.sv]
// ----------------------------------------------------------------------------
// qea_regs: APB configuration registers
// Holds step size and the saturation bounds; zero wait state access.
// ----------------------------------------------------------------------------
module qea_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [qea_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output qea_pkg::t_cfg              o_cfg
);
    import qea_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_size <= 31'd6554;
            r_cfg.min_value <= 32'sd0;
            r_cfg.max_value <= 32'sd6553600;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_STEP: r_cfg.step_size <= pwdata[30:0];
                REG_MIN:  r_cfg.min_value <= pwdata;
                REG_MAX:  r_cfg.max_value <= pwdata;
                default:  ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (w_idx)
            REG_STEP: prdata = {1'b0, r_cfg.step_size};
            REG_MIN:  prdata = r_cfg.min_value;
            REG_MAX:  prdata = r_cfg.max_value;
            default:  prdata = 32'd0;
        endcase
    end

endmodule

[rtl/qea_core.sv]
// ----------------------------------------------------------------------------
// qea_core: decoder table step and saturating accumulator
// Advances the state table on each accepted sample and updates the value.
// ----------------------------------------------------------------------------
module qea_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  qea_pkg::t_in_word   i_word,
    input  qea_pkg::t_cfg       i_cfg,
    output qea_pkg::t_out_word  o_word
);
    import qea_pkg::*;

    localparam logic signed [SUM_W-1:0] HI_LIM = SUM_W'((64'sd1 <<< (VALUE_W - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] LO_LIM = -HI_LIM - SUM_W'(1);

    logic [2:0]                 r_state, n_state;
    logic signed [VALUE_W-1:0]  r_acc, n_acc;
    logic [5:0]                 w_entry;
    logic [5:0]                 w_ev;
    logic signed [SUM_W-1:0]    w_acc_x, w_step_x, w_min_x, w_max_x, w_sum, w_sat;
    t_dir                       w_dir;

    // table lookup
    assign w_entry = NEXT_TAB[r_state][{i_word.pin_b, i_word.pin_a}];
    assign w_ev    = w_entry & EV_MASK;
    assign n_state = 3'(w_entry & ST_MASK);

    assign w_acc_x  = SUM_W'(r_acc);
    assign w_step_x = SUM_W'({1'b0, i_cfg.step_size});
    assign w_min_x  = SUM_W'(i_cfg.min_value);
    assign w_max_x  = SUM_W'(i_cfg.max_value);

    // step, then clamp: max, min, then the accumulator range
    always_comb begin
        w_dir = DIR_IDLE;
        w_sum = w_acc_x;
        if (w_ev == EV_CW) begin
            w_dir = DIR_CW;
            w_sum = w_acc_x + w_step_x;
        end else if (w_ev == EV_CCW) begin
            w_dir = DIR_CCW;
            w_sum = w_acc_x - w_step_x;
        end
        w_sat = w_sum;
        if (w_sat > w_max_x) w_sat = w_max_x;
        if (w_sat < w_min_x) w_sat = w_min_x;
        if (w_sat > HI_LIM)  w_sat = HI_LIM;
        if (w_sat < LO_LIM)  w_sat = LO_LIM;
        n_acc = (w_dir == DIR_IDLE) ? r_acc : w_sat[VALUE_W-1:0];
    end

    // decoder state and accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_START;
            r_acc   <= '0;
        end else if (i_accept) begin
            r_state <= n_state;
            r_acc   <= n_acc;
        end
    end

    // result word for this sample
    logic signed [SUM_W-1:0] w_new_x;
    assign w_new_x          = SUM_W'(n_acc);
    assign o_word.value     = w_new_x[31:0];
    assign o_word.direction = w_dir;

endmodule

[rtl/qea_skid.sv]
// ----------------------------------------------------------------------------
// qea_skid: output register with skid stage
// Registers result words; the skid entry takes one word while the output holds.
// ----------------------------------------------------------------------------
module qea_skid (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  qea_pkg::t_out_word  i_word,
    output logic                o_stall,
    output logic                o_accept,
    output logic                o_valid,
    input  logic                i_stall,
    output qea_pkg::t_out_word  o_word
);
    import qea_pkg::*;

    logic      r_out_valid, r_skid_valid;
    t_out_word r_out_word, r_skid_word;

    assign o_stall  = r_skid_valid;
    assign o_accept = i_valid && !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_word   = r_out_word;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= o_accept;
            end
        end else if (o_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_stall) begin
            r_out_word <= r_skid_valid ? r_skid_word : i_word;
        end else if (o_accept) begin
            r_skid_word <= i_word;
        end
    end

endmodule

[rtl/quadrature_encoder_accumulator_top.sv]
// ----------------------------------------------------------------------------
// quadrature_encoder_accumulator_top: rotary encoder step accumulator
// Decodes full detents from pin samples and keeps a saturating Q16.16 value.
//
//   channel   direction   handshake            word
//   in        input       i_in_valid/o_in_stall  t_in_word  {pin_b, pin_a}
//   out       output      o_out_valid/i_out_stall t_out_word {value, direction}
//   cfg       input       APB psel/penable      step_size, min_value, max_value
//
// One sample per cycle unless stalled; each result is registered at the output.
// The table step and clamped add sit between the state registers and the
// output register. Reset clears the decoder state, value and buffers.
// A stalled output holds one more word in the skid stage, then stalls input.
// ----------------------------------------------------------------------------
module quadrature_encoder_accumulator_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  qea_pkg::t_in_word          i_in_word,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output qea_pkg::t_out_word         o_out_word,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [qea_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import qea_pkg::*;

    t_cfg      w_cfg;
    t_out_word w_res;
    logic      w_accept;

    qea_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    qea_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_word   (i_in_word),
        .i_cfg    (w_cfg),
        .o_word   (w_res)
    );

    qea_skid u_skid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .i_word   (w_res),
        .o_stall  (o_in_stall),
        .o_accept (w_accept),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_word   (o_out_word)
    );

endmodule

[tb/sv/tb_quadrature_encoder_accumulator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quadrature_encoder_accumulator_top: self-checking bench for the encoder
// Drives pin samples through the valid/stall input and decodes detents in a
// local copy of the full-step state table. It keeps its own saturating
// Q16.16 value and checks every output word against it. Registers are
// reprogrammed over APB between phases. The register values cover extreme
// steps, a zero step, tight bounds, inverted bounds and bounds near the
// bottom of the signed range. Both sides idle at random, and the receiver
// holds off for a long stretch once.
// ----------------------------------------------------------------------------
module tb_quadrature_encoder_accumulator_top;
    import qea_pkg::*;

    // full detent pin sequences, first sample in the low bits
    localparam logic [7:0] CW_PINS  = {2'd3, 2'd2, 2'd0, 2'd1};
    localparam logic [7:0] CCW_PINS = {2'd3, 2'd1, 2'd0, 2'd2};
    localparam int         HOLD_CYCLES = 300;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    t_in_word           i_in_word   = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_out_word          o_out_word;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [ADDR_W-1:0]  paddr       = '0;
    logic [31:0]        pwdata      = '0;
    logic [31:0]        prdata;
    logic               pready;

    // pending samples and expected output words
    t_in_word           sample_q[$];
    t_out_word          expected_q[$];
    t_out_word          got_word;
    t_out_word          want_word;
    int unsigned        fail_cnt = 0;

    // idle rates in percent and the receiver hold-off request
    int unsigned        send_idle_pct = 0;
    int unsigned        recv_idle_pct = 0;
    int unsigned        hold_req  = 0;
    int unsigned        hold_ack  = 0;
    int unsigned        hold_left = 0;

    // local copy of the registers and the decoder state
    logic [30:0]        cfg_step  = 31'd6554;
    logic signed [31:0] cfg_min   = 32'sd0;
    logic signed [31:0] cfg_max   = 32'sd6553600;
    logic [2:0]         enc_state = 3'd0;
    logic signed [31:0] enc_value = 32'sd0;

    quadrature_encoder_accumulator_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // advance the decoder by one sample and queue the expected word
    function automatic void step_decoder(t_in_word smp);
        logic [1:0]  pins;
        logic [11:0] row;
        t_dir        dir;
        longint      sum;
        t_out_word   w;
        pins = {smp.pin_b, smp.pin_a};
        dir  = DIR_IDLE;
        // next state per pin code, code 3 in the top bits
        case (enc_state)
            3'd0: row = {3'd0, 3'd4, 3'd2, 3'd0};
            3'd1: row = {3'd0, 3'd1, 3'd0, 3'd3};
            3'd2: row = {3'd0, 3'd0, 3'd2, 3'd3};
            3'd3: row = {3'd0, 3'd1, 3'd2, 3'd3};
            3'd4: row = {3'd0, 3'd4, 3'd0, 3'd6};
            3'd5: row = {3'd0, 3'd0, 3'd5, 3'd6};
            3'd6: row = {3'd0, 3'd4, 3'd5, 3'd6};
            default: row = '0;
        endcase
        if (pins == 2'd3 && enc_state == 3'd1) dir = DIR_CW;
        if (pins == 2'd3 && enc_state == 3'd5) dir = DIR_CCW;
        enc_state = row[pins*3 +: 3];
        // completed detent: add or subtract, clamp max first so min wins
        if (dir != DIR_IDLE) begin
            if (dir == DIR_CW) sum = longint'(enc_value) + longint'(cfg_step);
            else               sum = longint'(enc_value) - longint'(cfg_step);
            if (sum > longint'(cfg_max)) sum = longint'(cfg_max);
            if (sum < longint'(cfg_min)) sum = longint'(cfg_min);
            enc_value = sum[31:0];
        end
        w.value     = enc_value;
        w.direction = dir;
        expected_q.push_back(w);
    endfunction

    // sample driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_word  <= sample_q.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // prediction on every accepted sample
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            step_decoder(i_in_word);
        end
    end

    // receiver stall: long hold-off on request, else random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_req != hold_ack) begin
            hold_ack    <= hold_req;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // output checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got_word = o_out_word;
            if (expected_q.size() == 0) begin
                $error("unexpected word: value %0d direction %0d",
                       got_word.value, got_word.direction);
                fail_cnt++;
            end else begin
                want_word = expected_q.pop_front();
                if (got_word.value !== want_word.value) begin
                    $error("value: expected %0d, got %0d",
                           want_word.value, got_word.value);
                    fail_cnt++;
                end
                if (got_word.direction !== want_word.direction) begin
                    $error("direction: expected %0d, got %0d",
                           want_word.direction, got_word.direction);
                    fail_cnt++;
                end
            end
        end
    end

    // APB register write, local copy updated at the write edge
    task automatic apb_write(t_reg_idx idx, logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_STEP: cfg_step = data[30:0];
            REG_MIN:  cfg_min  = data;
            REG_MAX:  cfg_max  = data;
            default: ;
        endcase
    endtask

    task automatic set_regs(logic [31:0] step, logic [31:0] lo, logic [31:0] hi);
        apb_write(REG_STEP, step);
        apb_write(REG_MIN, lo);
        apb_write(REG_MAX, hi);
    endtask

    // wait until every sample is taken and every word has come back
    task automatic wait_drained();
        do @(negedge i_clk);
        while (sample_q.size() != 0 || i_in_valid || expected_q.size() != 0);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic push_pins(logic [1:0] pins);
        sample_q.push_back(t_in_word'(pins));
    endtask

    // mostly whole detents with contact bounce, the rest pin noise
    task automatic push_random(int unsigned n);
        int unsigned cnt;
        int unsigned reps;
        logic [7:0]  seq;
        cnt = 0;
        while (cnt < n) begin
            if ($urandom_range(3) != 0) begin
                seq = $urandom_range(1) ? CW_PINS : CCW_PINS;
                for (int k = 0; k < 4; k++) begin
                    reps = ($urandom_range(3) == 0) ? $urandom_range(2, 3) : 1;
                    repeat (reps) begin
                        push_pins(seq[k*2 +: 2]);
                        cnt++;
                    end
                end
            end else begin
                push_pins(2'($urandom_range(3)));
                cnt++;
            end
        end
    endtask

    task automatic set_idling(int unsigned mode);
        case (mode)
            0: begin send_idle_pct = 15; recv_idle_pct = 72; end
            1: begin send_idle_pct = 72; recv_idle_pct = 15; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
        endcase
    endtask

    // main sequence
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        set_idling(0);

        // directed part at reset register values
        push_pins(2'd3);                                   // rest at start
        for (int k = 0; k < 4; k++) push_pins(CCW_PINS[k*2 +: 2]); // floor at min
        for (int k = 0; k < 4; k++) push_pins(CW_PINS[k*2 +: 2]);
        push_pins(2'd1); push_pins(2'd1); push_pins(2'd0); push_pins(2'd0);
        push_pins(2'd2); push_pins(2'd2); push_pins(2'd3); // bounced detent
        push_pins(2'd1); push_pins(2'd3);                  // aborted clockwise
        push_pins(2'd2); push_pins(2'd3);                  // aborted ccw
        push_pins(2'd0);
        push_pins(2'd1); push_pins(2'd0); push_pins(2'd2); // back and forth
        push_pins(2'd0); push_pins(2'd2); push_pins(2'd3);
        wait_drained();

        // extreme step with full signed bounds
        set_regs(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        push_random(155);
        wait_drained();

        // random moderate settings, long receiver hold-off mid phase
        set_regs($urandom_range(1, 32'h4_0000), -$urandom_range(1, 32'h40_0000),
                 $urandom_range(1, 32'h40_0000));
        push_random(75);
        hold_req++;
        push_random(80);
        wait_drained();

        // zero step and tight bounds: value may start outside them
        set_idling(1);
        set_regs(32'd0, -32'sd100, 32'sd100);
        push_random(155);
        wait_drained();

        // inverted bounds, min wins
        set_regs($urandom_range(1, 32'h7fff_ffff), 32'sd1000, -32'sd1000);
        push_random(155);
        wait_drained();

        // window at the bottom of the signed range
        set_idling(2);
        set_regs(32'd3000, 32'h8000_0000, 32'h8000_2710);
        push_random(155);
        wait_drained();

        // reset values again, sender pauses until everything has come back
        set_regs(32'd6554, 32'sd0, 32'sd6553600);
        push_random(78);
        wait_drained();
        push_random(78);
        wait_drained();

        repeat (10) @(negedge i_clk);
        if (expected_q.size() != 0) begin
            $error("%0d expected words never arrived", expected_q.size());
            fail_cnt++;
        end
        if (fail_cnt == 0) begin
            $display("quadrature_encoder_accumulator_top test passed");
        end else begin
            $display("quadrature_encoder_accumulator_top test failed");
        end
        $finish;
    end

    // run time limit
    initial begin
        #2000000;
        $display("quadrature_encoder_accumulator_top test failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/qea_pkg.sv
rtl/qea_regs.sv
rtl/qea_core.sv
rtl/qea_skid.sv
rtl/quadrature_encoder_accumulator_top.sv
tb/sv/tb_quadrature_encoder_accumulator_top.sv
